>>> rtl/core/rlcfs_pkg.sv
// Package for the RGB LED chain frame sender: shared types, field widths,
// opcodes, register indexes and word modes. No dependencies.
package rlcfs_pkg;

  localparam int unsigned LevelW = 10;
  localparam int unsigned IdxW   = 5;
  localparam int unsigned CountW = 6;
  localparam int unsigned CorrW  = 7;
  localparam int unsigned ColorW = 3 * LevelW;
  localparam int unsigned WordW  = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 7;

  // opcodes
  localparam logic OpSet     = 1'b0;
  localparam logic OpRefresh = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegModuleCount = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCorrRed     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCorrGreen   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCorrBlue    = 3'd3;

  // reset values
  localparam logic [CountW-1:0] ModuleCountRst = 6'd1;
  localparam logic [CorrW-1:0]  CorrRedRst     = 7'd120;
  localparam logic [CorrW-1:0]  CorrGreenRst   = 7'd100;
  localparam logic [CorrW-1:0]  CorrBlueRst    = 7'd100;

  // word modes in bits 31:30
  localparam logic [1:0] ModePwm  = 2'b00;
  localparam logic [1:0] ModeCorr = 2'b01;

  // command passed from front to back
  typedef struct packed {
    logic              refresh;
    logic [IdxW-1:0]   idx;
    logic [ColorW-1:0] color;   // blue, red, green
  } cmd_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkPwm,
    BkCorr
  } back_state_e;

endpackage

>>> rtl/core/rgb_led_chain_frame_sender.sv
// Top level of the RGB LED chain frame sender: configuration registers,
// front end, command queue and back end. Depends on rlcfs_pkg and rlcfs_* modules.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------------------------
//  command   | start_i, busy_o           | opcode_i, module_index_i, *_level_i
//  result    | result_strobe_o           | frame_word_o, latch_after_o, last_word_o
//  config    | cfg_we_i                  | cfg_index_i, cfg_wdata_i
//
// A command transfer completes when start_i is high and busy_o low; busy_o only
// rises when the two-entry queue is full. A colour store is written while the back end
// is idle. A refresh of N modules (N = module count, saturated) holds the back end
// through its BkPwm and BkCorr states and gives 2*N words on consecutive cycles, which
// reach the result ports through the memory read, word build and result register.
// Results cannot be stalled.
// Reset clears the colour store via per-module valid bits and loads the
// register defaults; no clearing pass is needed.
module rgb_led_chain_frame_sender #(
  parameter int unsigned MaxModules = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command channel
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                opcode_i,
  input  logic [rlcfs_pkg::IdxW-1:0]          module_index_i,
  input  logic [rlcfs_pkg::LevelW-1:0]        red_level_i,
  input  logic [rlcfs_pkg::LevelW-1:0]        green_level_i,
  input  logic [rlcfs_pkg::LevelW-1:0]        blue_level_i,
  // result channel
  output logic                                result_strobe_o,
  output logic [rlcfs_pkg::WordW-1:0]         frame_word_o,
  output logic                                latch_after_o,
  output logic                                last_word_o,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [rlcfs_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [rlcfs_pkg::CfgDataW-1:0]      cfg_wdata_i
);

  logic [rlcfs_pkg::CountW-1:0] module_count_q;
  logic [rlcfs_pkg::CorrW-1:0]  corr_red_q, corr_green_q, corr_blue_q;

  logic            q_push, q_full, q_pop, q_empty;
  rlcfs_pkg::cmd_t q_in, q_out;

  // configuration registers; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      module_count_q <= rlcfs_pkg::ModuleCountRst;
      corr_red_q     <= rlcfs_pkg::CorrRedRst;
      corr_green_q   <= rlcfs_pkg::CorrGreenRst;
      corr_blue_q    <= rlcfs_pkg::CorrBlueRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rlcfs_pkg::RegModuleCount: module_count_q <= cfg_wdata_i[rlcfs_pkg::CountW-1:0];
        rlcfs_pkg::RegCorrRed:     corr_red_q     <= cfg_wdata_i;
        rlcfs_pkg::RegCorrGreen:   corr_green_q   <= cfg_wdata_i;
        rlcfs_pkg::RegCorrBlue:    corr_blue_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  rlcfs_front #(
    .MaxModules (MaxModules)
  ) u_front (
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .module_index_i (module_index_i),
    .red_level_i    (red_level_i),
    .green_level_i  (green_level_i),
    .blue_level_i   (blue_level_i),
    .module_count_i (module_count_q),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_cmd_o        (q_in)
  );

  rlcfs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (q_out)
  );

  rlcfs_back #(
    .MaxModules (MaxModules)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_cmd_i        (q_out),
    .q_pop_o        (q_pop),
    .module_count_i (module_count_q),
    .corr_red_i     (corr_red_q),
    .corr_green_i   (corr_green_q),
    .corr_blue_i    (corr_blue_q),
    .strobe_o       (result_strobe_o),
    .frame_word_o   (frame_word_o),
    .latch_after_o  (latch_after_o),
    .last_word_o    (last_word_o)
  );

endmodule

>>> rtl/core/rlcfs_front.sv
// Front end: takes start transfers, classifies them and pushes useful commands
// into the queue. Depends on rlcfs_pkg.
module rlcfs_front #(
  parameter int unsigned MaxModules = 32
) (
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            opcode_i,
  input  logic [rlcfs_pkg::IdxW-1:0]      module_index_i,
  input  logic [rlcfs_pkg::LevelW-1:0]    red_level_i,
  input  logic [rlcfs_pkg::LevelW-1:0]    green_level_i,
  input  logic [rlcfs_pkg::LevelW-1:0]    blue_level_i,
  input  logic [rlcfs_pkg::CountW-1:0]    module_count_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output rlcfs_pkg::cmd_t                 q_cmd_o
);

  localparam logic [rlcfs_pkg::CountW-1:0] MaxCount = rlcfs_pkg::CountW'(MaxModules);

  logic accept;
  logic useful;

  assign busy_o = q_full_i;
  assign accept = start_i && !q_full_i;

  // stores beyond MaxModules and refreshes of an empty chain are dropped here
  always_comb begin
    unique case (opcode_i)
      rlcfs_pkg::OpSet:     useful = {1'b0, module_index_i} < MaxCount;
      rlcfs_pkg::OpRefresh: useful = module_count_i != '0;
      default:              useful = 1'b0;
    endcase
  end

  assign q_push_o        = accept && useful;
  assign q_cmd_o.refresh = (opcode_i == rlcfs_pkg::OpRefresh);
  assign q_cmd_o.idx     = module_index_i;
  assign q_cmd_o.color   = {blue_level_i, red_level_i, green_level_i};

endmodule

>>> rtl/core/rlcfs_queue.sv
// Two-entry command queue between front and back end.
// Depends on rlcfs_pkg.
module rlcfs_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rlcfs_pkg::cmd_t cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output rlcfs_pkg::cmd_t cmd_o
);

  rlcfs_pkg::cmd_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;

  assign full_o  = fill_q[1];
  assign empty_o = (fill_q == 2'd0);
  assign cmd_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    fill_d   = fill_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

>>> rtl/core/rlcfs_back.sv
// Back end: colour memory, refresh sequencer and result registers.
// Depends on rlcfs_pkg.
module rlcfs_back #(
  parameter int unsigned MaxModules = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_empty_i,
  input  rlcfs_pkg::cmd_t                  q_cmd_i,
  output logic                             q_pop_o,
  input  logic [rlcfs_pkg::CountW-1:0]     module_count_i,
  input  logic [rlcfs_pkg::CorrW-1:0]      corr_red_i,
  input  logic [rlcfs_pkg::CorrW-1:0]      corr_green_i,
  input  logic [rlcfs_pkg::CorrW-1:0]      corr_blue_i,
  output logic                             strobe_o,
  output logic [rlcfs_pkg::WordW-1:0]      frame_word_o,
  output logic                             latch_after_o,
  output logic                             last_word_o
);

  localparam int unsigned AddrW = (MaxModules > 1) ? $clog2(MaxModules) : 1;
  localparam logic [rlcfs_pkg::CountW-1:0] MaxCount = rlcfs_pkg::CountW'(MaxModules);
  localparam int unsigned CW = rlcfs_pkg::ColorW;

  rlcfs_pkg::back_state_e state_q, state_d;
  logic [rlcfs_pkg::CountW-1:0] cnt_q, cnt_d;
  logic [rlcfs_pkg::CountW-1:0] n_sat, n_last;
  logic at_last;

  logic             mem_we, rd_en;
  logic [AddrW-1:0] waddr;
  logic [CW-1:0]    mem [MaxModules];
  logic [CW-1:0]    rdata_q;
  logic [MaxModules-1:0] valid_q;

  // stage 1: memory read / correction select
  logic s1_vld_q, s1_vld_d;
  logic s1_corr_q, s1_corr_d;
  logic s1_latch_q, s1_latch_d;
  logic s1_last_q, s1_last_d;
  logic s1_hit_q;

  // result registers
  logic                         strobe_q;
  logic [rlcfs_pkg::WordW-1:0]  word_q, word_d;
  logic                         latch_q, last_q;

  assign n_sat   = (module_count_i > MaxCount) ? MaxCount : module_count_i;
  assign n_last  = n_sat - 1'b1;
  assign at_last = (cnt_q == n_last);
  assign waddr   = q_cmd_i.idx[AddrW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rlcfs_pkg::BkIdle: if (!q_empty_i && q_cmd_i.refresh) state_d = rlcfs_pkg::BkPwm;
      rlcfs_pkg::BkPwm:  if (at_last) state_d = rlcfs_pkg::BkCorr;
      rlcfs_pkg::BkCorr: if (at_last) state_d = rlcfs_pkg::BkIdle;
      default:           state_d = rlcfs_pkg::BkIdle;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop_o    = 1'b0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    cnt_d      = cnt_q;
    s1_vld_d   = 1'b0;
    s1_corr_d  = 1'b0;
    s1_latch_d = 1'b0;
    s1_last_d  = 1'b0;
    unique case (state_q)
      rlcfs_pkg::BkIdle: begin
        q_pop_o = !q_empty_i;
        mem_we  = !q_empty_i && !q_cmd_i.refresh;
        cnt_d   = '0;
      end
      rlcfs_pkg::BkPwm: begin
        rd_en      = 1'b1;
        s1_vld_d   = 1'b1;
        s1_latch_d = at_last;
        cnt_d      = at_last ? '0 : cnt_q + 1'b1;
      end
      rlcfs_pkg::BkCorr: begin
        s1_vld_d   = 1'b1;
        s1_corr_d  = 1'b1;
        s1_latch_d = at_last;
        s1_last_d  = at_last;
        cnt_d      = cnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rlcfs_pkg::BkIdle;
      cnt_q    <= '0;
      s1_vld_q <= 1'b0;
      strobe_q <= 1'b0;
      valid_q  <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      s1_vld_q <= s1_vld_d;
      strobe_q <= s1_vld_q;
      if (mem_we) valid_q[waddr] <= 1'b1;
    end
  end

  // colour memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= q_cmd_i.color;
    if (rd_en) begin
      rdata_q  <= mem[cnt_q[AddrW-1:0]];
      s1_hit_q <= valid_q[cnt_q[AddrW-1:0]];
    end
  end

  always_comb begin
    if (s1_corr_q) begin
      word_d = {rlcfs_pkg::ModeCorr,
                3'b000, corr_blue_i, 3'b000, corr_red_i, 3'b000, corr_green_i};
    end else begin
      word_d = {rlcfs_pkg::ModePwm, s1_hit_q ? rdata_q : {CW{1'b0}}};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_corr_q  <= s1_corr_d;
    s1_latch_q <= s1_latch_d;
    s1_last_q  <= s1_last_d;
    word_q     <= word_d;
    latch_q    <= s1_latch_q;
    last_q     <= s1_last_q;
  end

  assign strobe_o      = strobe_q;
  assign frame_word_o  = word_q;
  assign latch_after_o = latch_q;
  assign last_word_o   = last_q;

endmodule
